// ===== rtl/bit_error_window_average_macros.svh =====
// ----------------------------------------------------------------------------
// Bit error window average: assertion macros
// Concurrent assertion wrappers; empty when compiled for synthesis.
// ----------------------------------------------------------------------------
`ifndef BIT_ERROR_WINDOW_AVERAGE_MACROS_SVH
`define BIT_ERROR_WINDOW_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset
`define BEWA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle
`define BEWA_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`else

`define BEWA_ASSERT(name, clk, rst, prop, msg)
`define BEWA_ASSERT_NEXT(name, clk, rst, pre, post, msg)

`endif

`endif

// ===== rtl/bewa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit error window average package
// Widths, limits, register indexes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package bewa_pkg;

   // Storage limits
   localparam int MAX_VECTOR_LEN = 64;
   localparam int MAX_WINDOW     = 4096;

   // Field widths
   localparam int LEN_W  = 7;
   localparam int WIN_W  = 13;
   localparam int POS_W  = 6;
   localparam int VEC_W  = 12;
   localparam int SUM_W  = 16;
   localparam int AVG_W  = 20;
   localparam int PC_W   = 4;
   localparam int REM_W  = 12;
   localparam int CNT_W  = 5;
   localparam int IDX_W  = 2;

   // Divider runs one quotient bit per step
   localparam int DIV_STEPS = AVG_W;

   // Largest average: 8.0 in 4.16 fixed point
   localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(524288);

   // Configuration register indexes
   localparam logic [IDX_W-1:0] CSR_VECTOR_LENGTH  = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_WINDOW_VECTORS = IDX_W'(1);

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } state_type;

   // Count set bits of an error mask byte
   function automatic logic [PC_W-1:0] popcount8(input logic [7:0] v);
      logic [PC_W-1:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + PC_W'(v[i]);
      end
      return c;
   endfunction

endpackage

// ===== rtl/bit_error_window_average.sv =====
// Flow: an accepted byte is captured, then its sum is written back in the sum
// step. A byte that closes its window then runs the shared restoring divider,
// which makes one quotient bit per cycle over 20 bits (skipped when the
// average saturates), and waits until the output register is free. A new
// byte is taken only when the last one is through and the sequencer is idle.
// Reset: synchronous, active high; clears control, both registers to 1.
// ----------------------------------------------------------------------------
// Bit error window average
// Keeps a per-position popcount sum over a window of vectors and returns the
// average bit errors per position in 4.16 unsigned fixed point.
// ----------------------------------------------------------------------------
`include "bit_error_window_average_macros.svh"

module bit_error_window_average
   import bewa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_error_bits,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [AVG_W-1:0]     rsp_average_errors,
   output logic [POS_W-1:0]     rsp_position,
   output logic                 rsp_last_position,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [WIN_W-1:0]     csr_data
);

   // Sequencer and counters
   state_type              state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [VEC_W-1:0]       vcnt_ff, vcnt_in;

   // Configuration
   logic [LEN_W-1:0]       len_ff;
   logic [WIN_W-1:0]       win_ff;
   logic [LEN_W-1:0]       len_eff;
   logic [WIN_W-1:0]       win_eff;

   // Captured item
   logic [POS_W-1:0]       item_pos_ff;
   logic                   item_last_pos_ff;
   logic                   item_last_vec_ff;
   logic                   item_first_ff;
   logic [PC_W-1:0]        pc_ff;
   logic [SUM_W-1:0]       rd_data_ff;

   // Divider
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [AVG_W-1:0]       lo_ff, lo_in;
   logic [AVG_W-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]       rsp_avg_ff;
   logic [POS_W-1:0]       rsp_pos_ff;
   logic                   rsp_last_ff;

   // Sum memory
   logic [SUM_W-1:0]       sums_mem [MAX_VECTOR_LEN];

   logic                   accept;
   logic                   out_load;
   logic                   wr_en;
   logic [SUM_W-1:0]       wr_data;
   logic [SUM_W-1:0]       sum;
   logic                   saturate;
   logic [REM_W:0]         trial;
   logic                   trial_ge;
   logic                   last_pos;
   logic                   last_vec;

   // Clamp configuration to the supported range
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_VECTOR_LEN)) begin
         len_eff = LEN_W'(MAX_VECTOR_LEN);
      end else begin
         len_eff = len_ff;
      end
      if (win_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_ff > WIN_W'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = win_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign last_pos = ({1'b0, pos_ff} + LEN_W'(1)) >= len_eff;
   assign last_vec = ({1'b0, vcnt_ff} + WIN_W'(1)) >= win_eff;

   // Load popcount on the first vector, else accumulate
   assign sum = item_first_ff ? SUM_W'(pc_ff) : (rd_data_ff + SUM_W'(pc_ff));

   // Average above 8.0 exactly when sum exceeds 8 times the window
   assign saturate = sum > {win_eff, 3'b000};

   // One restoring divider step
   assign trial    = {rem_ff, lo_ff[AVG_W-1]};
   assign trial_ge = trial >= win_eff;

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      vcnt_in      = vcnt_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      wr_en        = 1'b0;
      wr_data      = sum;
      out_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // Store the new sum, or restart it when the window closes
            wr_en   = 1'b1;
            wr_data = item_last_vec_ff ? '0 : sum;
            if (item_last_pos_ff) begin
               pos_in  = '0;
               vcnt_in = item_last_vec_ff ? '0 : vcnt_ff + VEC_W'(1);
            end else begin
               pos_in  = pos_ff + POS_W'(1);
            end
            if (!item_last_vec_ff) begin
               state_in = ST_IDLE;
            end else if (saturate) begin
               quo_in   = AVG_MAX;
               state_in = ST_DONE;
            end else begin
               // Upper quotient bits are zero: start with the sum's high bits
               rem_in   = sum[SUM_W-1:SUM_W-REM_W];
               lo_in    = {sum[SUM_W-REM_W-1:0], 16'h0000};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? REM_W'(trial - win_eff) : trial[REM_W-1:0];
            lo_in  = {lo_ff[AVG_W-2:0], 1'b0};
            quo_in = {quo_ff[AVG_W-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         vcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= LEN_W'(1);
         win_ff       <= WIN_W'(1);
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         vcnt_ff      <= vcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VECTOR_LENGTH:  len_ff <= csr_data[LEN_W-1:0];
               CSR_WINDOW_VECTORS: win_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_pos_ff      <= pos_ff;
         item_last_pos_ff <= last_pos;
         item_last_vec_ff <= last_vec;
         item_first_ff    <= (vcnt_ff == '0);
         pc_ff            <= popcount8(req_error_bits);
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (out_load) begin
         rsp_avg_ff  <= quo_ff;
         rsp_pos_ff  <= item_pos_ff;
         rsp_last_ff <= item_last_pos_ff;
      end
   end

   // Sum memory: read on accept, write back in the sum step
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= sums_mem[pos_ff];
      end
      if (wr_en) begin
         sums_mem[item_pos_ff] <= wr_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_average_errors = rsp_avg_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_last_position  = rsp_last_ff;

   // Checks
   `BEWA_ASSERT(a_div_count, clock, reset, (state_ff != ST_DIV) || (cnt_ff < CNT_W'(DIV_STEPS)), "divider step count out of range")
   `BEWA_ASSERT(a_rem_below_win, clock, reset, (state_ff != ST_DIV) || ({1'b0, rem_ff} < win_eff), "divider remainder not below window")
   `BEWA_ASSERT_NEXT(a_load_from_done, clock, reset, !rsp_valid_ff, !rsp_valid_ff || ($past(state_ff) == ST_DONE), "result raised outside the hand-over step")
   `BEWA_ASSERT(a_avg_max, clock, reset, !rsp_valid_ff || (rsp_avg_ff <= AVG_MAX), "average above saturation limit")

endmodule
